// ===== hdl/slfc_pkg.sv =====
// -----------------------------------------------------------------------------
// Segment LCD frame composer - shared definitions
// Field widths, command codes, glyph bytes, digit tables and the structs that
// pass between the number pipeline and the frame stage.
// -----------------------------------------------------------------------------
package slfc_pkg;

   localparam int CMD_W  = 4;
   localparam int VAL_W  = 16;
   localparam int SYM_W  = 3;
   localparam int FACE_W = 3;
   localparam int SEC_W  = 32;
   localparam int SEG_W  = 8;
   localparam int IDX_W  = 3;

   localparam int FRAME_BYTES = 6;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

   typedef logic [FRAME_BYTES-1:0][SEG_W-1:0] frame_type;

   localparam frame_type FRAME_RESET = {FRAME_BYTES{8'hFF}};
   localparam frame_type SENT_RESET  = '0;

   typedef enum logic [CMD_W-1:0] {
      CMD_BIG      = 4'd0,
      CMD_SMALL    = 4'd1,
      CMD_TEMPSYM  = 4'd2,
      CMD_FACE     = 4'd3,
      CMD_BLE      = 4'd4,
      CMD_LINK     = 4'd5,
      CMD_BATT     = 4'd6,
      CMD_OTA      = 4'd7,
      CMD_ERR      = 4'd8,
      CMD_RESETSCR = 4'd9,
      CMD_CLOCK    = 4'd10,
      CMD_REFRESH  = 4'd11
   } cmd_type;

   // glyphs, upper row and lower row
   localparam logic [7:0] TOP_HI_H = 8'h67;
   localparam logic [7:0] TOP_HI_I = 8'h04;
   localparam logic [7:0] TOP_LO_L = 8'h85;
   localparam logic [7:0] TOP_LO_O = 8'hC6;
   localparam logic [7:0] TOP_T    = 8'h87;
   localparam logic [7:0] TOP_A    = 8'hF6;
   localparam logic [7:0] TOP_E    = 8'h97;
   localparam logic [7:0] BOT_H    = 8'h76;
   localparam logic [7:0] BOT_I    = 8'h10;
   localparam logic [7:0] BOT_L    = 8'h51;
   localparam logic [7:0] BOT_O    = 8'h33;
   localparam logic [7:0] BOT_E    = 8'h79;

   localparam logic [7:0] BIG_MINUS   = 8'h02;
   localparam logic [7:0] BIG_ONE_K   = 8'h08;
   localparam logic [7:0] BIG_POINT   = 8'h08;
   localparam logic [7:0] SMALL_MINUS = 8'h20;

   function automatic logic [7:0] big_digit(input logic [3:0] d);
      logic [7:0] seg;
      case (d)
         4'd0:    seg = 8'hF5;
         4'd1:    seg = 8'h60;
         4'd2:    seg = 8'hB6;
         4'd3:    seg = 8'hF2;
         4'd4:    seg = 8'h63;
         4'd5:    seg = 8'hD3;
         4'd6:    seg = 8'hD7;
         4'd7:    seg = 8'h70;
         4'd8:    seg = 8'hF7;
         4'd9:    seg = 8'hF3;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

   function automatic logic [7:0] small_digit(input logic [3:0] d);
      logic [7:0] seg;
      case (d)
         4'd0:    seg = 8'h5F;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h3D;
         4'd3:    seg = 8'h2F;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6B;
         4'd6:    seg = 8'h7B;
         4'd7:    seg = 8'h0E;
         4'd8:    seg = 8'h7F;
         4'd9:    seg = 8'h6F;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [SYM_W-1:0]  sym;
      logic [FACE_W-1:0] face;
      logic              flag;
   } ctl_type;

   // precomputed segment bytes for the number and clock commands
   typedef struct packed {
      logic [7:0] big0;
      logic [7:0] big1;
      logic [7:0] big2;
      logic [7:0] sm4;
      logic [7:0] sm5;
      logic [7:0] ck0;
      logic [7:0] ck1;
      logic [7:0] ck4;
      logic [7:0] ck5;
   } glyph_type;

   typedef struct packed {
      logic      valid;
      ctl_type   ctl;
      glyph_type glyph;
   } item_type;

endpackage

// ===== hdl/slfc_req_if.sv =====
// -----------------------------------------------------------------------------
// Segment LCD frame composer - command channel
// Valid/ready channel carrying one display command word.
// -----------------------------------------------------------------------------
interface slfc_req_if;
   import slfc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic signed [VAL_W-1:0]  value;
   logic [SYM_W-1:0]         temp_symbol;
   logic [FACE_W-1:0]        face;
   logic                     flag;
   logic [SEC_W-1:0]         seconds;

   modport source (output valid, command, value, temp_symbol, face, flag, seconds,
                   input ready);
   modport sink   (input valid, command, value, temp_symbol, face, flag, seconds,
                   output ready);
endinterface

// ===== hdl/slfc_rsp_if.sv =====
// -----------------------------------------------------------------------------
// Segment LCD frame composer - frame byte channel
// Valid/ready channel carrying one frame byte and its position.
// -----------------------------------------------------------------------------
interface slfc_rsp_if;
   import slfc_pkg::*;

   logic             valid;
   logic             ready;
   logic [SEG_W-1:0] segment_byte;
   logic [IDX_W-1:0] byte_index;
   logic             last;

   modport source (output valid, segment_byte, byte_index, last, input ready);
   modport sink   (input valid, segment_byte, byte_index, last, output ready);
endinterface

// ===== hdl/slfc_digits.sv =====
// -----------------------------------------------------------------------------
// Segment LCD frame composer - number pipeline
// Input register and five stages that turn the value and seconds fields into
// segment bytes for the big number, small number and clock. Divisions by
// constants are reciprocal multiplies.
// -----------------------------------------------------------------------------
module slfc_digits (
   input  logic               clock,
   input  logic               reset,
   slfc_req_if.sink           req_bus,
   input  logic               adv,
   output slfc_pkg::item_type item
);
   import slfc_pkg::*;

   localparam int STAGES = 6;

   localparam logic [30:0] RCP15_30 = 31'd1145324613;
   localparam logic [25:0] RCP15_25 = 26'd35791395;
   localparam logic [18:0] RCP3_18  = 19'd349526;
   localparam logic [15:0] RCP10_15 = 16'd52429;
   localparam logic [11:0] RCP10_11 = 12'd3277;
   localparam logic [8:0]  RCP10_8  = 9'd410;
   localparam logic [7:0]  RCP10_7  = 8'd205;
   localparam logic [6:0]  RCP10_6  = 7'd103;
   localparam logic [5:0]  RCP10_5  = 6'd52;

   typedef struct packed {
      logic hi;
      logic lo;
      logic neg;
      logic scaled;
   } bflag_type;

   typedef struct packed {
      logic hi;
      logic lo;
      logic neg;
   } sflag_type;

   logic    [STAGES-1:0] vld_ff;
   ctl_type              ctl_ff [STAGES];

   // input register
   logic signed [VAL_W-1:0] val0_ff;
   logic [SEC_W-1:0]        secs0_ff;

   // stage 1
   bflag_type   bf1_in, bf1_ff;
   sflag_type   sf1_in, sf1_ff;
   logic [14:0] babs1_in, babs1_ff;
   logic [6:0]  smag1_in, smag1_ff;
   logic [26:0] t1_in, t1_ff;
   logic signed [16:0] val_wide, vp5, bsrc, babs_full, vabs_full;
   logic [60:0] tprod;

   // stage 2
   bflag_type   bf2_ff;
   sflag_type   sf2_ff;
   logic [10:0] bmag2_in, bmag2_ff;
   logic [20:0] q2_2_in, q2_2_ff;
   logic [26:0] t2_ff;
   logic [3:0]  stens2_in, stens2_ff;
   logic [6:0]  smag2_ff;
   logic [30:0] bprod;
   logic [50:0] q2prod;
   logic [14:0] stprod;

   // stage 3
   bflag_type   bf3_ff;
   sflag_type   sf3_ff;
   logic [7:0]  q10_3_in, q10_3_ff;
   logic [10:0] bmag3_ff;
   logic [5:0]  mins3_in, mins3_ff;
   logic [15:0] q3_3_in, q3_3_ff;
   logic [20:0] q2_3_ff;
   logic [3:0]  sones3_in, sones3_ff, stens3_ff;
   logic [22:0] q10prod;
   logic [26:0] mins_full;
   logic [36:0] q3prod;
   logic [6:0]  sones_full;

   // stage 4
   bflag_type   bf4_ff;
   logic [3:0]  bones4_in, bones4_ff;
   logic [4:0]  q100_4_in, q100_4_ff;
   logic [7:0]  q10_4_ff;
   logic [4:0]  hrs4_in, hrs4_ff;
   logic [5:0]  mins4_ff;
   logic [7:0]  sm4_4_in, sm4_4_ff, sm5_4_in, sm5_4_ff;
   logic [10:0] bones_full;
   logic [16:0] q100prod;
   logic [20:0] hrs_full;

   // stage 5
   glyph_type   glyph5_in, glyph5_ff;
   logic [7:0]  btens_full;
   logic [3:0]  btens, bhund, htens, hones, mtens, mones;
   logic [4:0]  bhund_full, hones_full;
   logic [10:0] hprod;
   logic [12:0] mprod;
   logic [5:0]  mones_full;

   assign req_bus.ready = adv;

   // stage 1: range checks, magnitude, seconds to minutes
   always_comb begin
      val_wide      = 17'(val0_ff);
      vp5           = val_wide + 17'sd5;
      bf1_in.hi     = val0_ff > 16'sd19995;
      bf1_in.lo     = val0_ff < -16'sd995;
      bf1_in.scaled = (val0_ff > 16'sd1999) || (val0_ff < -16'sd99);
      bsrc          = bf1_in.scaled ? vp5 : val_wide;
      bf1_in.neg    = bsrc[16];
      babs_full     = bsrc[16] ? -bsrc : bsrc;
      babs1_in      = babs_full[14:0];
      sf1_in.hi     = val0_ff > 16'sd99;
      sf1_in.lo     = val0_ff < -16'sd9;
      sf1_in.neg    = val0_ff[15];
      vabs_full     = val_wide[16] ? -val_wide : val_wide;
      smag1_in      = vabs_full[6:0];
      tprod         = 61'(secs0_ff[31:2]) * 61'(RCP15_30);
      t1_in         = tprod[60:34];
   end

   // stage 2: scaled value / 10, minutes / 60, small tens
   always_comb begin
      bprod     = 31'(babs1_ff) * 31'(RCP10_15);
      bmag2_in  = bf1_ff.scaled ? bprod[29:19] : babs1_ff[10:0];
      q2prod    = 51'(t1_ff[26:2]) * 51'(RCP15_25);
      q2_2_in   = q2prod[49:29];
      stprod    = 15'(smag1_ff) * 15'(RCP10_7);
      stens2_in = stprod[14:11];
   end

   // stage 3: magnitude / 10, minute of hour, hours / 24, small ones
   always_comb begin
      q10prod    = 23'(bmag2_ff) * 23'(RCP10_11);
      q10_3_in   = q10prod[22:15];
      mins_full  = t2_ff - 27'(27'(q2_2_ff) * 27'd60);
      mins3_in   = mins_full[5:0];
      q3prod     = 37'(q2_2_ff[20:3]) * 37'(RCP3_18);
      q3_3_in    = q3prod[35:20];
      sones_full = smag2_ff - 7'(7'(stens2_ff) * 7'd10);
      sones3_in  = sones_full[3:0];
   end

   // stage 4: ones digit, hundreds, hour of day, small number bytes
   always_comb begin
      bones_full = bmag3_ff - 11'(11'(q10_3_ff) * 11'd10);
      bones4_in  = bones_full[3:0];
      q100prod   = 17'(q10_3_ff) * 17'(RCP10_8);
      q100_4_in  = q100prod[16:12];
      hrs_full   = q2_3_ff - 21'(21'(q3_3_ff) * 21'd24);
      hrs4_in    = hrs_full[4:0];
      if (sf3_ff.hi) begin
         sm5_4_in = BOT_H;
         sm4_4_in = BOT_I;
      end else if (sf3_ff.lo) begin
         sm5_4_in = BOT_L;
         sm4_4_in = BOT_O;
      end else begin
         sm5_4_in = (sf3_ff.neg ? SMALL_MINUS : 8'h00)
                  | ((stens3_ff != 4'd0) ? small_digit(stens3_ff) : 8'h00);
         sm4_4_in = small_digit(sones3_ff);
      end
   end

   // stage 5: remaining digits and segment bytes
   always_comb begin
      btens_full = q10_4_ff - 8'(8'(q100_4_ff) * 8'd10);
      btens      = btens_full[3:0];
      if (q100_4_ff >= 5'd20) begin
         bhund_full = q100_4_ff - 5'd20;
      end else if (q100_4_ff >= 5'd10) begin
         bhund_full = q100_4_ff - 5'd10;
      end else begin
         bhund_full = q100_4_ff;
      end
      bhund = bhund_full[3:0];

      hprod      = 11'(hrs4_ff) * 11'(RCP10_5);
      htens      = {2'b00, hprod[10:9]};
      hones_full = hrs4_ff - 5'(5'(htens) * 5'd10);
      hones      = hones_full[3:0];
      mprod      = 13'(mins4_ff) * 13'(RCP10_6);
      mtens      = {1'b0, mprod[12:10]};
      mones_full = mins4_ff - 6'(6'(mtens) * 6'd10);
      mones      = mones_full[3:0];

      if (bf4_ff.hi) begin
         glyph5_in.big0 = TOP_HI_H;
         glyph5_in.big1 = TOP_HI_I;
         glyph5_in.big2 = 8'h00;
      end else if (bf4_ff.lo) begin
         glyph5_in.big0 = TOP_LO_L;
         glyph5_in.big1 = TOP_LO_O;
         glyph5_in.big2 = 8'h00;
      end else begin
         glyph5_in.big0 = (bf4_ff.neg ? BIG_MINUS : 8'h00)
                        | ((q100_4_ff >= 5'd10) ? BIG_ONE_K : 8'h00)
                        | ((q100_4_ff != 5'd0) ? big_digit(bhund) : 8'h00);
         glyph5_in.big1 = big_digit(btens);
         glyph5_in.big2 = (bf4_ff.scaled ? 8'h00 : BIG_POINT) | big_digit(bones4_ff);
      end
      glyph5_in.sm4 = sm4_4_ff;
      glyph5_in.sm5 = sm5_4_ff;
      glyph5_in.ck0 = big_digit(htens);
      glyph5_in.ck1 = big_digit(hones);
      glyph5_in.ck4 = small_digit(mones);
      glyph5_in.ck5 = small_digit(mtens);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STAGES-2:0], req_bus.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff[0] <= '{cmd: req_bus.command, sym: req_bus.temp_symbol,
                        face: req_bus.face, flag: req_bus.flag};
         for (int k = 1; k < STAGES; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
         val0_ff   <= req_bus.value;
         secs0_ff  <= req_bus.seconds;

         bf1_ff    <= bf1_in;
         sf1_ff    <= sf1_in;
         babs1_ff  <= babs1_in;
         smag1_ff  <= smag1_in;
         t1_ff     <= t1_in;

         bf2_ff    <= bf1_ff;
         sf2_ff    <= sf1_ff;
         bmag2_ff  <= bmag2_in;
         q2_2_ff   <= q2_2_in;
         t2_ff     <= t1_ff;
         stens2_ff <= stens2_in;
         smag2_ff  <= smag1_ff;

         bf3_ff    <= bf2_ff;
         sf3_ff    <= sf2_ff;
         q10_3_ff  <= q10_3_in;
         bmag3_ff  <= bmag2_ff;
         mins3_ff  <= mins3_in;
         q3_3_ff   <= q3_3_in;
         q2_3_ff   <= q2_2_ff;
         sones3_ff <= sones3_in;
         stens3_ff <= stens2_ff;

         bf4_ff    <= bf3_ff;
         bones4_ff <= bones4_in;
         q100_4_ff <= q100_4_in;
         q10_4_ff  <= q10_3_ff;
         hrs4_ff   <= hrs4_in;
         mins4_ff  <= mins3_ff;
         sm4_4_ff  <= sm4_4_in;
         sm5_4_ff  <= sm5_4_in;

         glyph5_ff <= glyph5_in;
      end
   end

   assign item = '{valid: vld_ff[STAGES-1], ctl: ctl_ff[STAGES-1], glyph: glyph5_ff};

endmodule

// ===== hdl/slfc_frame.sv =====
// -----------------------------------------------------------------------------
// Segment LCD frame composer - frame stage
// Holds the frame and the last sent frame, applies one command per cycle unless a sending
// command waits on a burst, and streams the six sent bytes when one finds a changed frame.
// -----------------------------------------------------------------------------
module slfc_frame (
   input  logic               clock,
   input  logic               reset,
   input  slfc_pkg::item_type item,
   output logic               adv,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   slfc_rsp_if.source         rsp_bus
);
   import slfc_pkg::*;

   frame_type        frame_in, frame_ff;
   frame_type        sent_in, sent_ff;
   logic             busy_in, busy_ff;
   logic [IDX_W-1:0] idx_in, idx_ff;
   logic             disabled_in, disabled_ff;
   logic             emit_cmd;
   logic             fire;
   logic             do_emit;

   always_comb begin
      frame_in = frame_ff;
      emit_cmd = 1'b0;
      case (cmd_type'(item.ctl.cmd))
         CMD_BIG: begin
            frame_in[3][2:0] = item.ctl.sym;
            frame_in[0]      = item.glyph.big0;
            frame_in[1]      = (frame_ff[1] & 8'h08) | item.glyph.big1;
            frame_in[2]      = item.glyph.big2;
         end
         CMD_SMALL: begin
            frame_in[4]    = (frame_ff[4] & 8'h80) | item.glyph.sm4;
            frame_in[5]    = (frame_ff[5] & 8'h80) | item.glyph.sm5;
            frame_in[3][4] = item.ctl.flag;
         end
         CMD_TEMPSYM: begin
            frame_in[3][2:0] = item.ctl.sym;
         end
         CMD_FACE: begin
            frame_in[1][3] = item.ctl.face[2];
            frame_in[3][5] = item.ctl.face[0];
            frame_in[3][6] = item.ctl.face[1];
         end
         CMD_BLE: begin
            frame_in[4][7] = item.ctl.flag;
         end
         CMD_LINK: begin
            frame_in[3][7] = item.ctl.flag;
         end
         CMD_BATT: begin
            frame_in[5][7] = item.ctl.flag;
         end
         CMD_OTA: begin
            frame_in[0] = TOP_LO_O;
            frame_in[1] = TOP_T;
            frame_in[2] = TOP_A;
            frame_in[3] = frame_ff[3] & 8'h80;
            frame_in[4] = 8'h80;
            frame_in[5] = frame_ff[5] & 8'h80;
            emit_cmd    = 1'b1;
         end
         CMD_ERR: begin
            frame_in[0] = BOT_E;
            frame_in[1] = BOT_E;
            frame_in[2] = 8'h00;
            frame_in[3] = frame_ff[3] & 8'h80;
            frame_in[4] = (frame_ff[4] & 8'h80) | TOP_E;
            frame_in[5] = (frame_ff[5] & 8'h80) | TOP_E;
         end
         CMD_RESETSCR: begin
            frame_in[0] = TOP_LO_O;
            frame_in[1] = TOP_LO_O;
            frame_in[2] = 8'h00;
            frame_in[3] = 8'h00;
            frame_in[4] = BOT_O;
            frame_in[5] = BOT_O;
            emit_cmd    = 1'b1;
         end
         CMD_CLOCK: begin
            frame_in[0] = item.glyph.ck0;
            frame_in[1] = item.glyph.ck1;
            frame_in[2] = 8'h00;
            frame_in[3] = frame_ff[3] & 8'h80;
            frame_in[4] = (frame_ff[4] & 8'h80) | item.glyph.ck4;
            frame_in[5] = (frame_ff[5] & 8'h80) | item.glyph.ck5;
         end
         CMD_REFRESH: begin
            emit_cmd = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // an emitting command waits here until the previous six bytes are out
   assign adv     = !(item.valid && emit_cmd && busy_ff);
   assign fire    = item.valid && adv;
   assign do_emit = fire && emit_cmd && !disabled_ff && (frame_in != sent_ff);

   always_comb begin
      sent_in     = sent_ff;
      busy_in     = busy_ff;
      idx_in      = idx_ff;
      disabled_in = csr_wr_en ? csr_wr_data : disabled_ff;
      if (do_emit) begin
         sent_in = frame_in;
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (busy_ff && rsp_bus.ready) begin
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff    <= FRAME_RESET;
         sent_ff     <= SENT_RESET;
         busy_ff     <= 1'b0;
         idx_ff      <= '0;
         disabled_ff <= 1'b0;
      end else begin
         if (fire) begin
            frame_ff <= frame_in;
         end
         sent_ff     <= sent_in;
         busy_ff     <= busy_in;
         idx_ff      <= idx_in;
         disabled_ff <= disabled_in;
      end
   end

   assign rsp_bus.valid        = busy_ff;
   assign rsp_bus.segment_byte = sent_ff[idx_ff];
   assign rsp_bus.byte_index   = idx_ff;
   assign rsp_bus.last         = (idx_ff == LAST_IDX);

endmodule

// ===== hdl/segment_lcd_frame_composer.sv =====
// -----------------------------------------------------------------------------
// Segment LCD frame composer
// Builds the six-byte segment frame of a number display from commands and
// streams the frame bytes to the display driver on refresh.
// -----------------------------------------------------------------------------
// A command word is taken every clock. It passes an input register and five
// number stages (reciprocal multiplies for the tenths, digit and clock
// splits) and then updates the frame, so its bytes can leave from the
// cycle after. Refresh, OTA and reset screens send the six bytes,
// one word per cycle with byte_index 0 to 5, when the frame differs from the
// last one sent and csr_wr_data last written was 0; the output holds a
// byte until it is taken. While six bytes are still going out, another
// sending command stops at the frame stage and holds the command channel;
// every other command keeps flowing at one word per cycle.
module segment_lcd_frame_composer (
   input  logic       clock,
   input  logic       reset,
   slfc_req_if.sink   req_bus,
   slfc_rsp_if.source rsp_bus,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import slfc_pkg::*;

   item_type item;
   logic     adv;

   slfc_digits u_digits (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .adv     (adv),
      .item    (item)
   );

   slfc_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .item        (item),
      .adv         (adv),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_bus     (rsp_bus)
   );

`ifndef SYNTHESIS
   a_stall_only_while_sending: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid)
      else $error("command channel held with no frame bytes pending");

   a_burst_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> (rsp_bus.byte_index == '0))
      else $error("frame burst does not start at byte 0");

   a_burst_in_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !rsp_bus.last) |=>
      (rsp_bus.valid && (rsp_bus.byte_index == $past(rsp_bus.byte_index) + 3'd1)))
      else $error("frame burst broken or out of order");
`endif

endmodule

// ===== tb/tb_segment_lcd_frame_composer.sv =====
// -----------------------------------------------------------------------------
// Segment LCD frame composer - testbench
// Sends display command words and checks every frame byte that comes back
// against a local model of the frame and of the last frame sent. A directed
// table covers the range limits of the number displays, every command and the
// screen commands. Random words follow in phases with the display on, then
// off, then on again. Both channels stall in random bursts, except in the last
// phase, where neither side stalls.
// -----------------------------------------------------------------------------
module tb_segment_lcd_frame_composer;
   timeunit 1ns;
   timeprecision 1ps;

   import slfc_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE_TOP  = 4'd15;
   localparam logic [CMD_W-1:0] CMD_SPARE_LOW  = 4'd12;
   localparam int               SETTLE_CYCLES  = 16;
   localparam int               WATCHDOG_LIMIT = 2000;

   localparam logic [7:0] BIG_SEG [10] = '{
      8'hF5, 8'h60, 8'hB6, 8'hF2, 8'h63, 8'hD3, 8'hD7, 8'h70, 8'hF7, 8'hF3
   };
   localparam logic [7:0] SMALL_SEG [10] = '{
      8'h5F, 8'h06, 8'h3D, 8'h2F, 8'h66, 8'h6B, 8'h7B, 8'h0E, 8'h7F, 8'h6F
   };
   localparam int TENTHS_EDGES [13] = '{
      19995, -995, 1999, -99, 2000, -100, 0, 10, 100, 1000, 9995, -32768, 32767
   };

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic signed [VAL_W-1:0] value;
      logic [SYM_W-1:0]        sym;
      logic [FACE_W-1:0]       face;
      logic                    flag;
      logic [SEC_W-1:0]        secs;
   } lcd_cmd_type;

   // typed_bytes holds frame byte 0 in its top byte
   typedef struct packed {
      lcd_cmd_type word;
      logic        typed;
      logic [47:0] typed_bytes;
   } dir_row_type;

   typedef struct packed {
      logic [SEG_W-1:0] seg;
      logic [IDX_W-1:0] idx;
      logic             last;
   } lcd_byte_type;

   localparam dir_row_type DIRECTED [27] = '{
      '{'{CMD_REFRESH,  16'sd0,     3'd0, 3'd0, 1'b0, 32'd0}, 1'b1, 48'hFFFF_FFFF_FFFF},
      '{'{CMD_RESETSCR, 16'sd0,     3'd0, 3'd0, 1'b0, 32'd0}, 1'b1, 48'hC6C6_0000_3333},
      '{'{CMD_OTA,      16'sd0,     3'd0, 3'd0, 1'b0, 32'd0}, 1'b1, 48'hC687_F600_8000},
      '{'{CMD_BIG,      16'sh7FFF,  3'd0, 3'd0, 1'b0, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_REFRESH,  16'sd0,     3'd0, 3'd0, 1'b0, 32'd0}, 1'b1, 48'h6704_0000_8000},
      '{'{CMD_BIG,      16'sh8000,  3'd7, 3'd0, 1'b0, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_REFRESH,  16'sd0,     3'd0, 3'd0, 1'b0, 32'd0}, 1'b1, 48'h85C6_0007_8000},
      '{'{CMD_BIG,      16'sd19995, 3'd2, 3'd0, 1'b0, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_BIG,      -16'sd995,  3'd4, 3'd0, 1'b0, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_BIG,      16'sd1999,  3'd0, 3'd0, 1'b0, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_BIG,      -16'sd99,   3'd1, 3'd0, 1'b0, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_REFRESH,  16'sd0,     3'd0, 3'd0, 1'b0, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_SMALL,    16'sh7FFF,  3'd0, 3'd0, 1'b1, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_SMALL,    16'sh8000,  3'd0, 3'd0, 1'b0, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_SMALL,    -16'sd9,    3'd0, 3'd0, 1'b1, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_SMALL,    16'sd99,    3'd0, 3'd0, 1'b0, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_FACE,     16'sd0,     3'd0, 3'd7, 1'b0, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_TEMPSYM,  16'sd0,     3'd5, 3'd0, 1'b0, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_BLE,      16'sd0,     3'd0, 3'd0, 1'b1, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_LINK,     16'sd0,     3'd0, 3'd0, 1'b1, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_BATT,     16'sd0,     3'd0, 3'd0, 1'b1, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_REFRESH,  16'sd0,     3'd0, 3'd0, 1'b0, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_CLOCK,    16'sd0,     3'd0, 3'd0, 1'b0, 32'hFFFF_FFFF}, 1'b0, 48'h0},
      '{'{CMD_ERR,      16'sd0,     3'd0, 3'd0, 1'b0, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_REFRESH,  16'sd0,     3'd0, 3'd0, 1'b0, 32'd0}, 1'b0, 48'h0},
      '{'{CMD_SPARE_TOP, 16'shFFFF, 3'd7, 3'd7, 1'b1, 32'hFFFF_FFFF}, 1'b0, 48'h0},
      '{'{CMD_REFRESH,  16'sd0,     3'd0, 3'd0, 1'b0, 32'd0}, 1'b0, 48'h0}
   };

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   slfc_req_if req_bus ();
   slfc_rsp_if rsp_bus ();

   segment_lcd_frame_composer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [7:0]   frame_m [FRAME_BYTES];
   logic [7:0]   sent_m  [FRAME_BYTES];
   logic         display_off_m;
   lcd_byte_type expected_bytes [$];
   logic         idle_enabled;
   int           mismatch_count = 0;
   int           byte_count = 0;
   int           quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------- frame model ----------------
   function automatic void set_mask(input int i, input logic [7:0] mask, input logic on);
      if (on) begin
         frame_m[i] |= mask;
      end else begin
         frame_m[i] &= ~mask;
      end
   endfunction

   function automatic void draw_tenths(input int n);
      frame_m[0] = 8'h00;
      frame_m[1] &= 8'h08;
      frame_m[2] = 8'h00;
      if (n > 19995) begin
         frame_m[0] |= TOP_HI_H;
         frame_m[1] |= TOP_HI_I;
         return;
      end
      if (n < -995) begin
         frame_m[0] |= TOP_LO_L;
         frame_m[1] |= TOP_LO_O;
         return;
      end
      if (n > 1999 || n < -99) begin
         n = (n + 5) / 10;
      end else begin
         frame_m[2] = BIG_POINT;
      end
      if (n < 0) begin
         n = -n;
         frame_m[0] |= BIG_MINUS;
      end
      if (n > 999) frame_m[0] |= BIG_ONE_K;
      if (n > 99) frame_m[0] |= BIG_SEG[(n / 100) % 10];
      frame_m[1] |= (n > 9) ? BIG_SEG[(n / 10) % 10] : BIG_SEG[0];
      frame_m[2] |= BIG_SEG[n % 10];
   endfunction

   function automatic void draw_small(input int n, input logic pct);
      frame_m[4] &= 8'h80;
      frame_m[5] &= 8'h80;
      set_mask(3, 8'h10, pct);
      if (n > 99) begin
         frame_m[5] |= BOT_H;
         frame_m[4] |= BOT_I;
      end else if (n < -9) begin
         frame_m[5] |= BOT_L;
         frame_m[4] |= BOT_O;
      end else begin
         if (n < 0) begin
            n = -n;
            frame_m[5] |= SMALL_MINUS;
         end
         if (n > 9) frame_m[5] |= SMALL_SEG[(n / 10) % 10];
         frame_m[4] |= SMALL_SEG[n % 10];
      end
   endfunction

   function automatic void draw_clock(input logic [SEC_W-1:0] secs);
      int unsigned total_min;
      int unsigned mins;
      int unsigned hrs;
      total_min = secs / 60;
      mins = total_min % 60;
      hrs = (total_min / 60) % 24;
      frame_m[0] = BIG_SEG[hrs / 10];
      frame_m[1] = BIG_SEG[hrs % 10];
      frame_m[2] = 8'h00;
      frame_m[3] &= 8'h80;
      frame_m[4] = (frame_m[4] & 8'h80) | SMALL_SEG[mins % 10];
      frame_m[5] = (frame_m[5] & 8'h80) | SMALL_SEG[mins / 10];
   endfunction

   function automatic int push_frame();
      logic same;
      if (display_off_m) return 0;
      same = 1'b1;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         if (sent_m[i] != frame_m[i]) same = 1'b0;
      end
      if (same) return 0;
      sent_m = frame_m;
      return FRAME_BYTES;
   endfunction

   // updates the model frame; returns how many bytes go out (now in sent_m)
   function automatic int update_frame(input lcd_cmd_type w);
      case (w.cmd)
         CMD_BIG: begin
            frame_m[3] = {frame_m[3][7:3], w.sym};
            draw_tenths($signed(w.value));
         end
         CMD_SMALL: draw_small($signed(w.value), w.flag);
         CMD_TEMPSYM: frame_m[3] = {frame_m[3][7:3], w.sym};
         CMD_FACE: begin
            frame_m[1] &= ~8'h08;
            frame_m[3] &= ~8'h60;
            if (w.face[0]) frame_m[3] |= 8'h20;
            if (w.face[1]) frame_m[3] |= 8'h40;
            if (w.face[2]) frame_m[1] |= 8'h08;
         end
         CMD_BLE:  set_mask(4, 8'h80, w.flag);
         CMD_LINK: set_mask(3, 8'h80, w.flag);
         CMD_BATT: set_mask(5, 8'h80, w.flag);
         CMD_OTA: begin
            frame_m[0] = TOP_LO_O;
            frame_m[1] = TOP_T;
            frame_m[2] = TOP_A;
            frame_m[3] &= 8'h80;
            frame_m[4] = 8'h80;
            frame_m[5] &= 8'h80;
            return push_frame();
         end
         CMD_ERR: begin
            frame_m[0] = BOT_E;
            frame_m[1] = BOT_E;
            frame_m[2] = 8'h00;
            frame_m[3] &= 8'h80;
            frame_m[4] = (frame_m[4] & 8'h80) | TOP_E;
            frame_m[5] = (frame_m[5] & 8'h80) | TOP_E;
         end
         CMD_RESETSCR: begin
            frame_m[0] = TOP_LO_O;
            frame_m[1] = TOP_LO_O;
            frame_m[2] = 8'h00;
            frame_m[3] = 8'h00;
            frame_m[4] = BOT_O;
            frame_m[5] = BOT_O;
            return push_frame();
         end
         CMD_CLOCK:   draw_clock(w.secs);
         CMD_REFRESH: return push_frame();
         default: ;
      endcase
      return 0;
   endfunction

   // ---------------- stimulus ----------------
   function automatic lcd_cmd_type random_word();
      lcd_cmd_type w;
      int pick;
      pick = $urandom_range(0, 99);
      w.sym = SYM_W'($urandom_range(0, 7));
      w.face = FACE_W'($urandom_range(0, 7));
      w.flag = 1'($urandom_range(0, 1));
      w.secs = $urandom();
      w.value = VAL_W'($urandom_range(0, 65535));
      if (pick < 22) begin
         w.cmd = CMD_REFRESH;
      end else if (pick < 36) begin
         w.cmd = CMD_BIG;
         case ($urandom_range(0, 3))
            0: ;
            1: w.value = VAL_W'(int'($urandom_range(0, 2098)) - 99);
            2: w.value = VAL_W'(int'($urandom_range(0, 20990)) - 995);
            default: w.value = VAL_W'(TENTHS_EDGES[$urandom_range(0, 12)]
                                      + int'($urandom_range(0, 2)) - 1);
         endcase
      end else if (pick < 46) begin
         w.cmd = CMD_SMALL;
         if ($urandom_range(0, 3) != 0) w.value = VAL_W'(int'($urandom_range(0, 114)) - 12);
      end else if (pick < 51) w.cmd = CMD_TEMPSYM;
      else if (pick < 57) w.cmd = CMD_FACE;
      else if (pick < 62) w.cmd = CMD_BLE;
      else if (pick < 67) w.cmd = CMD_LINK;
      else if (pick < 72) w.cmd = CMD_BATT;
      else if (pick < 77) w.cmd = CMD_OTA;
      else if (pick < 82) w.cmd = CMD_ERR;
      else if (pick < 87) w.cmd = CMD_RESETSCR;
      else if (pick < 95) w.cmd = CMD_CLOCK;
      else w.cmd = CMD_W'($urandom_range(CMD_SPARE_LOW, CMD_SPARE_TOP));
      return w;
   endfunction

   task automatic send_word(input lcd_cmd_type w, input logic typed,
                            input logic [47:0] typed_bytes);
      int n;
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= w.cmd;
      req_bus.value       <= w.value;
      req_bus.temp_symbol <= w.sym;
      req_bus.face        <= w.face;
      req_bus.flag        <= w.flag;
      req_bus.seconds     <= w.secs;
      do @(posedge clock); while (!req_bus.ready);
      n = update_frame(w);
      for (int i = 0; i < n; i++) begin
         expected_bytes.push_back('{typed ? typed_bytes[47 - 8 * i -: 8] : sent_m[i],
                                    IDX_W'(i), i == FRAME_BYTES - 1});
      end
   endtask

   task automatic send_random(input int count);
      repeat (count) send_word(random_word(), 1'b0, 48'h0);
   endtask

   // drain, let no-output words clear the pipeline, then write the register
   task automatic set_display_off(input logic off);
      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= off;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      display_off_m = off;
   endtask

   initial begin
      foreach (frame_m[i]) frame_m[i] = 8'hFF;
      foreach (sent_m[i]) sent_m[i] = 8'h00;
      display_off_m       = 1'b0;
      idle_enabled        = 1'b1;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = 1'b0;
      req_bus.valid       = 1'b0;
      req_bus.command     = '0;
      req_bus.value       = '0;
      req_bus.temp_symbol = '0;
      req_bus.face        = '0;
      req_bus.flag        = 1'b0;
      req_bus.seconds     = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_display_off(1'b0);
      foreach (DIRECTED[r]) send_word(DIRECTED[r].word, DIRECTED[r].typed,
                                      DIRECTED[r].typed_bytes);
      send_random(80);
      set_display_off(1'b1);
      send_random(50);
      set_display_off(1'b0);
      send_random(70);
      idle_enabled = 1'b0;
      send_random(55);

      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** segment_lcd_frame_composer: PASSED **");
      end else begin
         $display("** segment_lcd_frame_composer: FAILED **");
      end
      $finish;
   end

   // ---------------- result side ----------------
   initial begin : rsp_stall_gen
      int hold;
      rsp_bus.ready = 1'b1;
      forever begin
         @(posedge clock);
         if (idle_enabled && !reset && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(1, 19);
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s at word %0d: got 0x%0h, expected 0x%0h",
               what, byte_count, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      lcd_byte_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("unexpected frame byte", int'(rsp_bus.segment_byte), 0);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_bus.segment_byte !== want.seg)
               report_mismatch("segment_byte", int'(rsp_bus.segment_byte),
                               int'(want.seg));
            if (rsp_bus.byte_index !== want.idx)
               report_mismatch("byte_index", int'(rsp_bus.byte_index), int'(want.idx));
            if (rsp_bus.last !== want.last)
               report_mismatch("last", int'(rsp_bus.last), int'(want.last));
         end
         byte_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("** segment_lcd_frame_composer: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ===== sim.f =====
hdl/slfc_pkg.sv
hdl/slfc_req_if.sv
hdl/slfc_rsp_if.sv
hdl/slfc_digits.sv
hdl/slfc_frame.sv
hdl/segment_lcd_frame_composer.sv
tb/tb_segment_lcd_frame_composer.sv
